>>> rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

   // Scale of the 8-bit channels and the width of one hue sector (in doubled hue).
   localparam int unsigned FULL_SCALE  = 255;
   localparam int unsigned SECTOR_SPAN = 85;
   localparam int unsigned FRAC_SCALE  = FULL_SCALE * SECTOR_SPAN;

   // Reciprocals for division by a constant: quotient estimate is (x * RECIP) >> SHIFT.
   // Each shift exceeds the numerator width, so the estimate is short by at most one.
   localparam int unsigned P_SHIFT = 24;
   localparam int unsigned Q_SHIFT = 32;
   localparam logic [16:0] P_RECIP = 17'((64'd1 << P_SHIFT) / FULL_SCALE);
   localparam logic [17:0] Q_RECIP = 18'((64'd1 << Q_SHIFT) / FRAC_SCALE);

   // Hue sectors; the top hue value lands in an extra sector that shares the last case.
   localparam logic [2:0] SECTOR_RED_UP   = 3'd0;
   localparam logic [2:0] SECTOR_GREEN_DN = 3'd1;
   localparam logic [2:0] SECTOR_GREEN_UP = 3'd2;
   localparam logic [2:0] SECTOR_BLUE_DN  = 3'd3;
   localparam logic [2:0] SECTOR_BLUE_UP  = 3'd4;
   localparam logic [2:0] SECTOR_RED_DN   = 3'd5;
   localparam logic [2:0] SECTOR_WRAP     = 3'd6;

   // Side information that travels with each word alongside the arithmetic.
   typedef struct packed {
      logic [2:0] sector;
      logic [7:0] val;
      logic [7:0] alpha;
      logic       grey;
   } tag_type;

endpackage

>>> rtl/hsvrgb_div.sv
module hsvrgb_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  hsvrgb_pkg::tag_type in_tag,
   input  logic [15:0]         in_p_num,
   input  logic [22:0]         in_q_num,
   input  logic [22:0]         in_t_num,
   output logic                out_vld,
   output hsvrgb_pkg::tag_type out_tag,
   output logic [7:0]          out_p,
   output logic [7:0]          out_q,
   output logic [7:0]          out_t
);
   import hsvrgb_pkg::*;

   // Stage one: reciprocal products and quotient estimates.
   logic [32:0] p_prod;
   logic [40:0] q_prod;
   logic [40:0] t_prod;
   logic [7:0]  est_p_in, est_q_in, est_t_in;
   logic [7:0]  est_p_ff, est_q_ff, est_t_ff;
   logic [15:0] num_p_ff;
   logic [22:0] num_q_ff, num_t_ff;
   logic        vld1_ff;
   tag_type     tag1_ff;

   assign p_prod   = 33'(in_p_num) * 33'(P_RECIP);
   assign q_prod   = 41'(in_q_num) * 41'(Q_RECIP);
   assign t_prod   = 41'(in_t_num) * 41'(Q_RECIP);
   assign est_p_in = p_prod[P_SHIFT+7:P_SHIFT];
   assign est_q_in = q_prod[Q_SHIFT+7:Q_SHIFT];
   assign est_t_in = t_prod[Q_SHIFT+7:Q_SHIFT];

   // Stage two: remainder left over by the estimate, below twice the divisor.
   logic [8:0]  rem_p_in, rem_p_ff;
   logic [15:0] rem_q_in, rem_q_ff;
   logic [15:0] rem_t_in, rem_t_ff;
   logic [15:0] back_p;
   logic [22:0] back_q, back_t;
   logic [7:0]  est2_p_ff, est2_q_ff, est2_t_ff;
   logic        vld2_ff;
   tag_type     tag2_ff;

   assign back_p   = 16'(est_p_ff) * 16'(FULL_SCALE);
   assign back_q   = 23'(est_q_ff) * 23'(FRAC_SCALE);
   assign back_t   = 23'(est_t_ff) * 23'(FRAC_SCALE);
   assign rem_p_in = 9'(num_p_ff - back_p);
   assign rem_q_in = 16'(num_q_ff - back_q);
   assign rem_t_in = 16'(num_t_ff - back_t);

   // Stage three: one correction step finishes each quotient.
   logic [7:0] p_in, q_in, t_in;
   logic [7:0] p_ff, q_ff, t_ff;
   logic       vld3_ff;
   tag_type    tag3_ff;

   assign p_in = est2_p_ff + 8'(rem_p_ff >= 9'(FULL_SCALE));
   assign q_in = est2_q_ff + 8'(rem_q_ff >= 16'(FRAC_SCALE));
   assign t_in = est2_t_ff + 8'(rem_t_ff >= 16'(FRAC_SCALE));

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      est_p_ff  <= est_p_in;
      est_q_ff  <= est_q_in;
      est_t_ff  <= est_t_in;
      num_p_ff  <= in_p_num;
      num_q_ff  <= in_q_num;
      num_t_ff  <= in_t_num;
      tag1_ff   <= in_tag;
      rem_p_ff  <= rem_p_in;
      rem_q_ff  <= rem_q_in;
      rem_t_ff  <= rem_t_in;
      est2_p_ff <= est_p_ff;
      est2_q_ff <= est_q_ff;
      est2_t_ff <= est_t_ff;
      tag2_ff   <= tag1_ff;
      p_ff      <= p_in;
      q_ff      <= q_in;
      t_ff      <= t_in;
      tag3_ff   <= tag2_ff;
   end

   assign out_vld = vld3_ff;
   assign out_tag = tag3_ff;
   assign out_p   = p_ff;
   assign out_q   = q_ff;
   assign out_t   = t_ff;

endmodule

>>> rtl/hsv_to_rgb_8bit.sv
// HSV to RGB converter for 8-bit pixels with alpha.
// Input: drive req_hue, req_saturation, req_brightness and req_alpha_in with start
// high; the word is taken at that clock edge whenever busy is low. busy never rises,
// so a new pixel can be taken every cycle.
// Output: each result word is on rsp_red, rsp_green, rsp_blue and rsp_alpha_out for
// exactly one cycle, marked by rsp_strobe, once its input has passed the stages below.
// Throughput is one pixel per clock; the pipeline registers are, in order: sector
// split, two product stages, three stages of constant division (reciprocal
// multiply, back-multiply, correction) and the channel select register.
// Results leave in input order. The receiver cannot stall, so the pipeline never
// holds and nothing is buffered.
// A synchronous reset clears all valid bits; words in flight are dropped and no
// strobe follows until new input arrives.
module hsv_to_rgb_8bit (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_hue,
   input  logic [7:0] req_saturation,
   input  logic [7:0] req_brightness,
   input  logic [7:0] req_alpha_in,
   output logic       rsp_strobe,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_alpha_out
);
   import hsvrgb_pkg::*;

   logic accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Stage one: split the doubled hue into sector and remainder.
   logic [8:0] twice;
   logic [8:0] base;
   logic [2:0] sector_in;
   logic [6:0] rem_in;
   tag_type    tag_in;

   assign twice = {req_hue, 1'b0};

   always_comb begin
      if (twice >= 9'(6 * SECTOR_SPAN)) begin
         sector_in = SECTOR_WRAP;
         base      = 9'(6 * SECTOR_SPAN);
      end else if (twice >= 9'(5 * SECTOR_SPAN)) begin
         sector_in = SECTOR_RED_DN;
         base      = 9'(5 * SECTOR_SPAN);
      end else if (twice >= 9'(4 * SECTOR_SPAN)) begin
         sector_in = SECTOR_BLUE_UP;
         base      = 9'(4 * SECTOR_SPAN);
      end else if (twice >= 9'(3 * SECTOR_SPAN)) begin
         sector_in = SECTOR_BLUE_DN;
         base      = 9'(3 * SECTOR_SPAN);
      end else if (twice >= 9'(2 * SECTOR_SPAN)) begin
         sector_in = SECTOR_GREEN_UP;
         base      = 9'(2 * SECTOR_SPAN);
      end else if (twice >= 9'(SECTOR_SPAN)) begin
         sector_in = SECTOR_GREEN_DN;
         base      = 9'(SECTOR_SPAN);
      end else begin
         sector_in = SECTOR_RED_UP;
         base      = 9'd0;
      end
   end

   assign rem_in        = 7'(twice - base);
   assign tag_in.sector = sector_in;
   assign tag_in.val    = req_brightness;
   assign tag_in.alpha  = req_alpha_in;
   assign tag_in.grey   = (req_saturation == 8'd0);

   logic       vld1_ff;
   tag_type    tag1_ff;
   logic [7:0] sat_ff;
   logic [6:0] rem_ff;

   // Stage two: first products.
   logic [15:0] ps_in, ps_ff;
   logic [14:0] sq_in, sq_ff;
   logic [14:0] st_in, st_ff;
   logic        vld2_ff;
   tag_type     tag2_ff;

   assign ps_in = 16'(tag1_ff.val) * 16'(8'(FULL_SCALE) - sat_ff);
   assign sq_in = 15'(sat_ff) * 15'(rem_ff);
   assign st_in = 15'(sat_ff) * 15'(7'(SECTOR_SPAN) - rem_ff);

   // Stage three: numerators of the fade-down and fade-up channels.
   logic [22:0] qn_in, qn_ff;
   logic [22:0] tn_in, tn_ff;
   logic [15:0] pn_ff;
   logic        vld3_ff;
   tag_type     tag3_ff;

   assign qn_in = 23'(tag2_ff.val) * 23'(15'(FRAC_SCALE) - sq_ff);
   assign tn_in = 23'(tag2_ff.val) * 23'(15'(FRAC_SCALE) - st_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= accept;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff <= tag_in;
      sat_ff  <= req_saturation;
      rem_ff  <= rem_in;
      ps_ff   <= ps_in;
      sq_ff   <= sq_in;
      st_ff   <= st_in;
      tag2_ff <= tag1_ff;
      pn_ff   <= ps_ff;
      qn_ff   <= qn_in;
      tn_ff   <= tn_in;
      tag3_ff <= tag2_ff;
   end

   // Division by the constant scales.
   logic       dvld;
   tag_type    dtag;
   logic [7:0] p_val, q_val, t_val;

   hsvrgb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vld3_ff),
      .in_tag   (tag3_ff),
      .in_p_num (pn_ff),
      .in_q_num (qn_ff),
      .in_t_num (tn_ff),
      .out_vld  (dvld),
      .out_tag  (dtag),
      .out_p    (p_val),
      .out_q    (q_val),
      .out_t    (t_val)
   );

   // Output stage: route value and the three derived levels to the channels.
   logic [7:0] red_in, green_in, blue_in;
   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic       strobe_ff;

   always_comb begin
      if (dtag.grey) begin
         red_in   = dtag.val;
         green_in = dtag.val;
         blue_in  = dtag.val;
      end else begin
         case (dtag.sector)
            SECTOR_RED_UP: begin
               red_in = dtag.val; green_in = t_val;    blue_in = p_val;
            end
            SECTOR_GREEN_DN: begin
               red_in = q_val;    green_in = dtag.val; blue_in = p_val;
            end
            SECTOR_GREEN_UP: begin
               red_in = p_val;    green_in = dtag.val; blue_in = t_val;
            end
            SECTOR_BLUE_DN: begin
               red_in = p_val;    green_in = q_val;    blue_in = dtag.val;
            end
            SECTOR_BLUE_UP: begin
               red_in = t_val;    green_in = p_val;    blue_in = dtag.val;
            end
            default: begin
               red_in = dtag.val; green_in = p_val;    blue_in = q_val;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dvld;
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      alpha_ff <= dtag.alpha;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_alpha_out = alpha_ff;

   // Every accepted word comes out as a result strobe, and no strobe comes without one.
   assert property (@(posedge clock) disable iff (reset) accept |-> ##7 rsp_strobe)
      else $error("accepted word did not produce a result after seven cycles");

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> $past(accept, 7))
      else $error("result strobe without a matching accepted word");

   // Alpha travels with its pixel through the whole pipeline.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_alpha_out == $past(req_alpha_in, 7))
      else $error("alpha does not match its pixel");

   // The brightness always appears on at least one channel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_red == $past(req_brightness, 7)) ||
                     (rsp_green == $past(req_brightness, 7)) ||
                     (rsp_blue == $past(req_brightness, 7)))
      else $error("no channel carries the brightness");

endmodule
